// File: rtl/mks_pkg.sv
package mks_pkg;

	// register indexes on the write port
	localparam logic [2:0] REG_SCAN_ENABLE    = 3'd0;
	localparam logic [2:0] REG_DEBOUNCE_COUNT = 3'd1;
	localparam logic [2:0] REG_REPEAT_DELAY   = 3'd2;
	localparam logic [2:0] REG_KEY_MAP_LOW    = 3'd3;
	localparam logic [2:0] REG_KEY_MAP_HIGH   = 3'd4;

	// sequencer phases
	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_SCAN  = 2'd1;
	localparam logic [1:0] PH_DELAY = 2'd2;

	localparam logic [4:0] NO_KEY       = 5'd16;
	localparam logic [3:0] ROWS_ALL_LOW = 4'h0;
	localparam logic [7:0] COUNT_MAX    = 8'hFF;

	typedef struct packed {
		logic [3:0] row_drive;
		logic       read_done;
		logic       key_found;
		logic [3:0] key_index;
		logic [7:0] key_code;
	} mks_result_t;

	// one row low, the others high
	function automatic logic [3:0] drive_for_row(input logic [1:0] row);
		logic [3:0] d;
		d = 4'hF;
		d[row] = 1'b0;
		return d;
	endfunction

	// lowest column reading low; only meaningful when some column is low
	function automatic logic [1:0] first_low_col(input logic [3:0] cols);
		logic [1:0] c;
		c = 2'd3;
		if (!cols[2]) c = 2'd2;
		if (!cols[1]) c = 2'd1;
		if (!cols[0]) c = 2'd0;
		return c;
	endfunction

endpackage

// File: rtl/mks_if.sv
// column sample channel
interface mks_in_if;
	logic       valid;
	logic       ready;
	logic [3:0] column_levels;

	modport source (output valid, output column_levels, input ready);
	modport sink   (input valid, input column_levels, output ready);
endinterface

// result channel
interface mks_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] row_drive;
	logic       read_done;
	logic       key_found;
	logic [3:0] key_index;
	logic [7:0] key_code;

	modport source (output valid, output row_drive, output read_done, output key_found,
		output key_index, output key_code, input ready);
	modport sink   (input valid, input row_drive, input read_done, input key_found,
		input key_index, input key_code, output ready);
endinterface

// File: rtl/matrix_keypad_scanner_debounced_core.sv
// channel   dir  word                                   handshake
// sample    in   column_levels[3:0]                     valid/ready
// result    out  row_drive, read_done, key_found,       valid/ready
//                key_index[3:0], key_code[7:0]
// write     in   wr_en, wr_index[2:0], wr_data[63:0]    wr_en only, no wait
//
// one sample word in, one result word out; one word per cycle sustained while result.ready stays high
// the sequencer update and result are one combinational pass into the result register
// a result is registered and appears in the cycle after its sample is taken
// arst_n clears the sequencer and loads register defaults, result register empties
// a stalled result holds; a new sample is taken in the same cycle the result leaves
module matrix_keypad_scanner_debounced_core
	import mks_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	mks_in_if.sink        sample,
	mks_out_if.source     result,
	input  logic          wr_en,
	input  logic [2:0]    wr_index,
	input  logic [63:0]   wr_data
);

	// configuration registers
	logic        scan_enable_q;
	logic [7:0]  debounce_count_q;
	logic [15:0] repeat_delay_q;
	logic [63:0] key_map_low_q;
	logic [63:0] key_map_high_q;

	// sequencer state
	logic [1:0]  phase_q;
	logic [1:0]  scan_row_q;
	logic [4:0]  last_value_q;
	logic [7:0]  match_count_q;
	logic [15:0] delay_count_q;

	// result register
	logic        res_valid_q;
	mks_result_t res_q;

	logic take;

	// next state and result of one tick
	logic [1:0]  phase_d;
	logic [1:0]  scan_row_d;
	logic [4:0]  last_value_d;
	logic [7:0]  match_count_d;
	logic [15:0] delay_count_d;
	mks_result_t res_d;

	// scan helpers
	logic [3:0]  cols;
	logic        any_low;
	logic        scan_ended;
	logic [4:0]  scan_value;
	logic [7:0]  need;
	logic [7:0]  match_next;
	logic [15:0] delay_dec;
	logic [63:0] map_word;

	// take a word whenever the result slot is empty or being emptied
	assign sample.ready = !res_valid_q || result.ready;
	assign take         = sample.valid && sample.ready;

	assign cols       = sample.column_levels;
	assign any_low    = (cols != 4'hF);
	assign scan_ended = any_low || (scan_row_q == 2'd3);
	assign scan_value = any_low ? {1'b0, scan_row_q, first_low_col(cols)} : NO_KEY;
	// zero debounce behaves as one
	assign need       = (debounce_count_q == 8'd0) ? 8'd1 : debounce_count_q;
	assign delay_dec  = (delay_count_q != 16'd0) ? delay_count_q - 16'd1 : 16'd0;
	assign map_word   = scan_value[3] ? key_map_high_q : key_map_low_q;

	always_comb begin
		if (scan_value == last_value_q) begin
			match_next = (match_count_q == COUNT_MAX) ? COUNT_MAX : match_count_q + 8'd1;
		end else begin
			match_next = 8'd1;
		end
	end

	always_comb begin
		phase_d       = phase_q;
		scan_row_d    = scan_row_q;
		last_value_d  = last_value_q;
		match_count_d = match_count_q;
		delay_count_d = delay_count_q;
		res_d         = '0;
		res_d.row_drive = ROWS_ALL_LOW;

		case (phase_q)
			PH_SCAN: begin
				if (!scan_ended) begin
					// nothing on this row, move to the next one
					scan_row_d      = scan_row_q + 2'd1;
					res_d.row_drive = drive_for_row(scan_row_q + 2'd1);
				end else begin
					last_value_d  = scan_value;
					match_count_d = match_next;
					scan_row_d    = 2'd0;
					if (match_next >= need) begin
						// debounced read complete, rows go back low
						res_d.read_done = 1'b1;
						if (!scan_value[4]) begin
							res_d.key_found = 1'b1;
							res_d.key_index = scan_value[3:0];
							res_d.key_code  = map_word[{scan_value[2:0], 3'b000} +: 8];
						end
						if (!scan_value[4] && (repeat_delay_q != 16'd0)) begin
							delay_count_d = repeat_delay_q;
							phase_d       = PH_DELAY;
						end else begin
							phase_d = PH_IDLE;
						end
					end else begin
						// not settled yet, rescan from row 0
						res_d.row_drive = drive_for_row(2'd0);
					end
				end
			end
			PH_DELAY: begin
				delay_count_d = delay_dec;
				if (delay_dec == 16'd0) phase_d = PH_IDLE;
			end
			default: begin
				// idle, and the unused code behaves as idle
				phase_d = PH_IDLE;
				if (scan_enable_q) begin
					last_value_d    = NO_KEY;
					match_count_d   = 8'd0;
					scan_row_d      = 2'd0;
					phase_d         = PH_SCAN;
					res_d.row_drive = drive_for_row(2'd0);
				end
			end
		endcase
	end

	// configuration writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_enable_q    <= 1'b0;
			debounce_count_q <= 8'd10;
			repeat_delay_q   <= 16'd1000;
			key_map_low_q    <= '0;
			key_map_high_q   <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_SCAN_ENABLE:    scan_enable_q    <= wr_data[0];
				REG_DEBOUNCE_COUNT: debounce_count_q <= wr_data[7:0];
				REG_REPEAT_DELAY:   repeat_delay_q   <= wr_data[15:0];
				REG_KEY_MAP_LOW:    key_map_low_q    <= wr_data;
				REG_KEY_MAP_HIGH:   key_map_high_q   <= wr_data;
				default: ;
			endcase
		end
	end

	// sequencer advances once per taken word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			scan_row_q    <= 2'd0;
			last_value_q  <= NO_KEY;
			match_count_q <= 8'd0;
			delay_count_q <= 16'd0;
		end else if (take) begin
			phase_q       <= phase_d;
			scan_row_q    <= scan_row_d;
			last_value_q  <= last_value_d;
			match_count_q <= match_count_d;
			delay_count_q <= delay_count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (take) res_q <= res_d;
	end

	assign result.valid     = res_valid_q;
	assign result.row_drive = res_q.row_drive;
	assign result.read_done = res_q.read_done;
	assign result.key_found = res_q.key_found;
	assign result.key_index = res_q.key_index;
	assign result.key_code  = res_q.key_code;

endmodule

// File: rtl/mks_checker.sv
module mks_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [3:0] row_drive,
	input logic       read_done,
	input logic       key_found,
	input logic [3:0] key_index,
	input logic [7:0] key_code
);

	// a found key is only reported with a completed read
	a_found_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && key_found |-> read_done)
		else $error("key_found without read_done");

	// index and code are zero when no key is reported
	a_idle_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !key_found |-> (key_index == 4'd0) && (key_code == 8'd0))
		else $error("key fields nonzero without key_found");

	// a completed read returns all rows low
	a_done_rows_low: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && read_done |-> (row_drive == 4'h0))
		else $error("rows not all low after read_done");

	// rows are either all low or exactly one row is driven low
	a_one_row_low: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (row_drive == 4'h0) || $onehot(~row_drive))
		else $error("illegal row drive pattern");

	// a stalled result word holds
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(row_drive) && $stable(read_done)
			&& $stable(key_found) && $stable(key_index) && $stable(key_code))
		else $error("result changed while stalled");

endmodule

bind matrix_keypad_scanner_debounced_core mks_checker u_mks_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.row_drive (result.row_drive),
	.read_done (result.read_done),
	.key_found (result.key_found),
	.key_index (result.key_index),
	.key_code  (result.key_code)
);

// File: bench/mks_result_checker.sv
module mks_result_checker
	import mks_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	mks_in_if           samples,
	mks_out_if          results,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [63:0] wr_data,
	input  logic        drain_check,
	output int          mismatches
);
	timeunit 1ns;
	timeprecision 1ps;

	// register copies
	logic        cfg_enable;
	logic [7:0]  cfg_debounce;
	logic [15:0] cfg_delay;
	logic [63:0] cfg_map_lo;
	logic [63:0] cfg_map_hi;

	// scanner state
	logic [1:0]  scan_phase;
	logic [1:0]  scan_row;
	logic [4:0]  last_scan;
	logic [7:0]  same_scans;
	logic [15:0] delay_left;

	mks_result_t due_results[$];

	task automatic report(input string what);
		$display("%0t ns  mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	function automatic void reset_scanner();
		cfg_enable   = 1'b0;
		cfg_debounce = 8'd10;
		cfg_delay    = 16'd1000;
		cfg_map_lo   = '0;
		cfg_map_hi   = '0;
		scan_phase   = PH_IDLE;
		scan_row     = 2'd0;
		last_scan    = NO_KEY;
		same_scans   = 8'd0;
		delay_left   = 16'd0;
	endfunction

	function automatic void load_register(input logic [2:0] idx, input logic [63:0] data);
		case (idx)
		REG_SCAN_ENABLE:    cfg_enable = data[0];
		REG_DEBOUNCE_COUNT: cfg_debounce = data[7:0];
		REG_REPEAT_DELAY:   cfg_delay = data[15:0];
		REG_KEY_MAP_LOW:    cfg_map_lo = data;
		REG_KEY_MAP_HIGH:   cfg_map_hi = data;
		default: ;
		endcase
	endfunction

	// one tick of the scanner for one column word
	function automatic mks_result_t scanner_tick(input logic [3:0] cols);
		mks_result_t r;
		logic [3:0]  low;
		logic [4:0]  val;
		logic [1:0]  col;
		logic [7:0]  need;
		logic [63:0] map;
		bit          ended;
		r = '0;
		r.row_drive = ROWS_ALL_LOW;
		low = ~cols;
		val = NO_KEY;
		col = 2'd0;
		ended = 1'b0;
		case (scan_phase)
		PH_SCAN: begin
			if (low != 4'h0) begin
				for (int c = 3; c >= 0; c--)
					if (low[c]) col = 2'(c);
				val = {1'b0, scan_row, col};
				ended = 1'b1;
			end else if (scan_row == 2'd3) begin
				ended = 1'b1;
			end else begin
				scan_row = scan_row + 2'd1;
				r.row_drive = ~(4'b0001 << scan_row);
			end
			if (ended) begin
				need = (cfg_debounce == 8'd0) ? 8'd1 : cfg_debounce;
				if (val == last_scan) begin
					if (same_scans != COUNT_MAX)
						same_scans = same_scans + 8'd1;
				end else begin
					last_scan = val;
					same_scans = 8'd1;
				end
				if (same_scans >= need) begin
					r.read_done = 1'b1;
					if (val != NO_KEY) begin
						r.key_found = 1'b1;
						r.key_index = val[3:0];
						map = val[3] ? cfg_map_hi : cfg_map_lo;
						r.key_code = map[val[2:0] * 8 +: 8];
					end
					if (r.key_found && cfg_delay != 16'd0) begin
						delay_left = cfg_delay;
						scan_phase = PH_DELAY;
					end else begin
						scan_phase = PH_IDLE;
					end
				end else begin
					r.row_drive = 4'b1110;
				end
				scan_row = 2'd0;
			end
		end
		PH_DELAY: begin
			if (delay_left != 16'd0)
				delay_left = delay_left - 16'd1;
			if (delay_left == 16'd0)
				scan_phase = PH_IDLE;
		end
		default: begin
			scan_phase = PH_IDLE;
			if (cfg_enable) begin
				last_scan = NO_KEY;
				same_scans = 8'd0;
				scan_row = 2'd0;
				scan_phase = PH_SCAN;
				r.row_drive = 4'b1110;
			end
		end
		endcase
		return r;
	endfunction

	task automatic compare_word(input mks_result_t want);
		if (results.row_drive !== want.row_drive)
			report($sformatf("row_drive %h, predicted %h", results.row_drive, want.row_drive));
		if (results.read_done !== want.read_done)
			report($sformatf("read_done %b, predicted %b", results.read_done, want.read_done));
		if (results.key_found !== want.key_found)
			report($sformatf("key_found %b, predicted %b", results.key_found, want.key_found));
		if (results.key_index !== want.key_index)
			report($sformatf("key_index %h, predicted %h", results.key_index, want.key_index));
		if (results.key_code !== want.key_code)
			report($sformatf("key_code %h, predicted %h", results.key_code, want.key_code));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_scanner();
			due_results.delete();
		end else begin
			if (results.valid && results.ready) begin
				if (due_results.size() == 0)
					report("result word with nothing due");
				else
					compare_word(due_results.pop_front());
			end
			if (samples.valid && samples.ready)
				due_results.push_back(scanner_tick(samples.column_levels));
			if (wr_en)
				load_register(wr_index, wr_data);
			if (drain_check && due_results.size() != 0) begin
				report($sformatf("%0d result words never arrived", due_results.size()));
				due_results.delete();
			end
		end
	end

endmodule

// File: bench/tb_matrix_keypad_scanner_debounced_core.sv
module tb_matrix_keypad_scanner_debounced_core;
	timeunit 1ns;
	timeprecision 1ps;
	import mks_pkg::*;

	localparam int         ITEM_GOAL        = 1050;
	// room left in the item budget for the closing stall and delay phases
	localparam int         TAIL_ITEMS       = 150;
	localparam int         LONG_STALL       = 200;
	localparam logic [2:0] REG_UNUSED_FIRST = 3'd5;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        wr_en;
	logic [2:0]  wr_index;
	logic [63:0] wr_data;
	logic        drain_check;
	int          fail_count;

	mks_in_if  sample_ch();
	mks_out_if result_ch();

	// driver bookkeeping; word counts and rows seen are updated in tick()
	int          words_sent = 0;
	int          words_back = 0;
	logic [3:0]  rows_seen = 4'h0;
	int          items_done = 0;

	// keypad model: bit r*4+c set means the key at row r, column c is down
	logic [15:0] keys_down = 16'h0;
	bit          bounce_on = 1'b1;

	// idle percentages; the receiver ones change only by nonblocking writes
	int          send_idle = 22;
	int          recv_idle = 63;
	int          stall_asks = 0;

	always #10 clk = ~clk;

	matrix_keypad_scanner_debounced_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (sample_ch),
		.result   (result_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	mks_result_checker result_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.samples     (sample_ch),
		.results     (result_ch),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.drain_check (drain_check),
		.mismatches  (fail_count)
	);

	// receiver: random back-pressure, plus a long hold-off on request
	initial begin
		int stall_left;
		int stall_taken;
		stall_left = 0;
		stall_taken = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_asks != stall_taken) begin
				stall_taken = stall_asks;
				stall_left = LONG_STALL;
			end
			if (stall_left != 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// one clock; handshakes are seen with their pre-edge values
	task automatic tick();
		@(posedge clk);
		if (sample_ch.valid && sample_ch.ready)
			words_sent++;
		if (result_ch.valid && result_ch.ready) begin
			words_back++;
			rows_seen = result_ch.row_drive;
		end
	endtask

	// column levels the pad shows while the given rows are driven
	function automatic logic [3:0] pad_columns(input logic [3:0] rows, input logic [15:0] down);
		logic [3:0] cols;
		cols = 4'hF;
		for (int r = 0; r < 4; r++)
			if (!rows[r])
				cols &= ~down[r*4 +: 4];
		return cols;
	endfunction

	function automatic logic [15:0] pick_keys();
		int roll;
		roll = $urandom_range(99);
		if (roll < 35)
			return 16'h0;
		if (roll < 85)
			return 16'h1 << $urandom_range(15);
		return (16'h1 << $urandom_range(15)) | (16'h1 << $urandom_range(15));
	endfunction

	// offer one column word; pad words wait for the row drive of the previous word
	task automatic put_word(input bit from_pad, input logic [3:0] raw);
		logic [3:0] cols;
		int         before_count;
		while ($urandom_range(99) < send_idle) begin
			sample_ch.valid <= 1'b0;
			tick();
		end
		if (from_pad) begin
			while (words_back != words_sent) begin
				sample_ch.valid <= 1'b0;
				tick();
			end
			cols = pad_columns(rows_seen, keys_down);
			// contact bounce
			if (bounce_on && $urandom_range(15) == 0)
				cols ^= 4'b0001 << $urandom_range(3);
		end else begin
			cols = raw;
		end
		sample_ch.valid <= 1'b1;
		sample_ch.column_levels <= cols;
		before_count = words_sent;
		do tick(); while (words_sent == before_count);
		items_done++;
	endtask

	// stop offering and let every result word come back
	task automatic settle();
		sample_ch.valid <= 1'b0;
		tick();
		while (words_back != words_sent)
			tick();
		repeat (2) tick();
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		tick();
	endtask

	// full register setup; upper data bits are junk the block must drop
	task automatic apply_setup(input bit en, input logic [7:0] deb, input logic [15:0] rep,
		input logic [63:0] lo, input logic [63:0] hi);
		logic [63:0] data;
		settle();
		data = {$urandom, $urandom};
		data[0] = en;
		write_reg(REG_SCAN_ENABLE, data);
		data = {$urandom, $urandom};
		data[7:0] = deb;
		write_reg(REG_DEBOUNCE_COUNT, data);
		data = {$urandom, $urandom};
		data[15:0] = rep;
		write_reg(REG_REPEAT_DELAY, data);
		write_reg(REG_KEY_MAP_LOW, lo);
		write_reg(REG_KEY_MAP_HIGH, hi);
		// an index past the register file must change nothing
		if ($urandom_range(3) == 0)
			write_reg(REG_UNUSED_FIRST + 3'($urandom_range(2)), {$urandom, $urandom});
		wr_en <= 1'b0;
		tick();
	endtask

	task automatic random_setup();
		logic [7:0]  deb;
		logic [15:0] rep;
		logic [63:0] lo;
		logic [63:0] hi;
		int          roll;
		roll = $urandom_range(9);
		// a zero debounce count behaves as one
		deb = (roll == 0) ? 8'd0 : (roll < 8) ? 8'($urandom_range(1, 4))
			: 8'($urandom_range(5, 12));
		roll = $urandom_range(9);
		rep = (roll < 3) ? 16'd0 : (roll < 8) ? 16'($urandom_range(1, 10))
			: 16'($urandom_range(11, 40));
		lo = {$urandom, $urandom};
		hi = {$urandom, $urandom};
		roll = $urandom_range(9);
		if (roll == 0) begin
			lo = '0;
			hi = '1;
		end else if (roll == 1) begin
			lo = '1;
			hi = '0;
		end
		// clearing enable lets a read already under way run to its end
		apply_setup($urandom_range(99) < 85, deb, rep, lo, hi);
	endtask

	// key presses held for a while, with a sprinkle of stray column words
	task automatic run_session(input int n_items);
		int hold;
		hold = 0;
		for (int i = 0; i < n_items; i++) begin
			if (hold == 0) begin
				keys_down = pick_keys();
				hold = $urandom_range(3, 40);
			end
			hold--;
			if ($urandom_range(9) == 0)
				put_word(1'b0, 4'($urandom_range(15)));
			else
				put_word(1'b1, 4'h0);
		end
	endtask

	// hard stop if the handshakes hang
	initial begin
		#10ms;
		$display("matrix_keypad_scanner_debounced_core verification failed");
		$finish;
	end

	initial begin
		logic [15:0] pad_cases[5];
		pad_cases = '{16'h0001, 16'h8000, 16'h0000, 16'h0C00, 16'h1020};
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = 3'd0;
		wr_data = '0;
		drain_check = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.column_levels = 4'h0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		tick();

		// reset registers: scanning is off, column words are ignored
		put_word(1'b0, 4'h0);
		put_word(1'b0, 4'hF);
		put_word(1'b0, 4'h5);

		// directed reads: corner keys, no key, two keys in one row (lowest column wins),
		// keys in two rows (first row wins); debounce zero accepts the first scan
		bounce_on = 1'b0;
		apply_setup(1'b1, 8'd0, 16'd0, {$urandom, $urandom}, 64'hFFFF_FFFF_FFFF_FFFF);
		foreach (pad_cases[k]) begin
			keys_down = pad_cases[k];
			repeat (5) put_word(1'b1, 4'h0);
		end

		items_done = 0;

		// longest debounce: one key on row 0 held still for 300 words, past the 255 matching scans needed
		apply_setup(1'b1, 8'd255, 16'd5, {$urandom, $urandom}, {$urandom, $urandom});
		keys_down = 16'h0001 << $urandom_range(3);
		repeat (300) put_word(1'b1, 4'h0);
		bounce_on = 1'b1;

		// random sessions; idling swaps a third of the way in, then stops
		while (items_done < ITEM_GOAL - TAIL_ITEMS) begin
			if (items_done >= 2 * ITEM_GOAL / 3) begin
				send_idle = 0;
				recv_idle <= 0;
			end else if (items_done >= ITEM_GOAL / 3) begin
				send_idle = 63;
				recv_idle <= 22;
			end
			random_setup();
			run_session($urandom_range(20, 80));
		end

		// long receiver hold-off while words keep coming, so the input stalls
		send_idle = 0;
		recv_idle <= 0;
		stall_asks <= stall_asks + 1;
		repeat (40) put_word(1'b0, 4'($urandom_range(15)));

		// a long repeat delay after a found key, then a fresh read
		bounce_on = 1'b0;
		apply_setup(1'b1, 8'd1, 16'd60, {$urandom, $urandom}, {$urandom, $urandom});
		keys_down = 16'h0020;
		repeat (6) put_word(1'b1, 4'h0);
		repeat (64) put_word(1'b0, 4'($urandom_range(15)));
		keys_down = 16'h0;
		repeat (12) put_word(1'b1, 4'h0);

		// drain, then ask the checker for leftovers
		recv_idle <= 0;
		settle();
		repeat (4) tick();
		drain_check <= 1'b1;
		tick();
		drain_check <= 1'b0;
		tick();
		@(negedge clk);
		if (fail_count == 0)
			$display("matrix_keypad_scanner_debounced_core verification clean");
		else
			$display("matrix_keypad_scanner_debounced_core verification failed");
		$finish;
	end

endmodule
